// ----- rtl/skrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range smoother package
// Shared types, constants and register codes of the range smoother.
// ----------------------------------------------------------------------------
package skrs_pkg;

    localparam int NUM_TAGS_DEF    = 8;
    localparam int NUM_ANCHORS_DEF = 4;

    localparam int DATA_W  = 32;   // Q16.16 estimate and variance
    localparam int NOISE_W = 24;   // Q8.16 noise registers
    localparam int GAIN_W  = 16;   // Q0.16 gain
    localparam int RANGE_W = 16;
    localparam int TAG_W   = 3;
    localparam int ANC_W   = 2;

    // The gain quotient needs one bit above Q0.16 before it saturates.
    localparam int DIV_STEPS = GAIN_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [GAIN_W:0] ONE_Q16 = (GAIN_W + 1)'(1) << GAIN_W;

    // Register codes: word index taken from paddr[2].
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DEN,
        ST_DIV,
        ST_MUL_DELTA,
        ST_MUL_VAR,
        ST_WRITE
    } t_state;

endpackage

// ----- rtl/skrs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one address port and registered read data.
// ----------------------------------------------------------------------------
module skrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/skrs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider forming floor(pm * 2^16 / den), one quotient bit a cycle,
// saturated to Q0.16; a zero denominator gives a zero gain.
// ----------------------------------------------------------------------------
module skrs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skrs_pkg::DATA_W-1:0]   i_num,
    input  logic [skrs_pkg::DATA_W:0]     i_den,
    output logic                          o_done,
    output logic [skrs_pkg::GAIN_W-1:0]   o_gain
);

    localparam int W = skrs_pkg::DATA_W;

    logic [W+1:0]                     r_rem;
    logic [W:0]                       r_den;
    logic [skrs_pkg::GAIN_W:0]        r_q;
    logic [skrs_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                             r_zero;
    logic                             r_done;

    logic         w_ge;
    logic [W+1:0] w_sub;

    // The numerator never exceeds the denominator, so the remainder stays
    // below twice the denominator after each shift.
    assign w_ge  = (r_rem >= {1'b0, r_den});
    assign w_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= skrs_pkg::DIV_CNT_W'(skrs_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == skrs_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (W + 2)'(i_num);
            r_den  <= i_den;
            r_q    <= '0;
            r_zero <= (i_den == '0);
        end else if (r_cnt != '0) begin
            r_rem <= {w_sub[W:0], 1'b0};
            r_q   <= {r_q[skrs_pkg::GAIN_W-1:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_gain = r_zero ? '0 :
                    r_q[skrs_pkg::GAIN_W] ? '1 : r_q[skrs_pkg::GAIN_W-1:0];

endmodule

// ----- rtl/scalar_kalman_range_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman range smoother
// One scalar Kalman filter per tag and anchor pair, state held in RAM.
// ----------------------------------------------------------------------------
// Range requests enter on the s_axis channel and filtered ranges leave on the
// m_axis channel. A request with the valid flag clear, or whose tag or anchor
// lies outside the table, is taken while idle and produces no result.
// A valid request reads its filter from the estimate and variance RAMs,
// predicts the variance, divides for the gain, updates both values and
// writes them back, then places one result in the output register.
// An update passes through the load, denominator, divide, delta multiply,
// variance multiply and write states; its result is loaded into the output
// register at the same edge as the write-back. The restoring gain divider
// resolves one quotient bit a cycle and takes up most of an update. A new
// request is taken only once the block is idle again after the write-back.
// Only one update is in flight, so no forwarding is needed.
// After reset the block sweeps both RAMs to zero, one entry a cycle, over all
// NUM_TAGS * NUM_ANCHORS entries (32 by default), and accepts no request
// meanwhile; the APB registers are writable throughout and reset to 1.0.
// While the receiver stalls, the result waits in the output register and a
// further request may still be accepted; its write-back waits until the
// output register has been emptied.
// ----------------------------------------------------------------------------
module scalar_kalman_range_smoother #(
    parameter int NUM_TAGS    = skrs_pkg::NUM_TAGS_DEF,
    parameter int NUM_ANCHORS = skrs_pkg::NUM_ANCHORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // tag_index[2:0], anchor_index[4:3],
                                       // range_value[20:5], zero fill
    input  logic        s_axis_tuser,  // range_valid
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // filtered_range[15:0], out_tag[18:16],
                                       // out_anchor[20:19], zero fill
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH  = NUM_TAGS * NUM_ANCHORS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W      = skrs_pkg::DATA_W;
    localparam int NW     = skrs_pkg::NOISE_W;
    localparam int GW     = skrs_pkg::GAIN_W;
    localparam int RW     = skrs_pkg::RANGE_W;
    localparam int TW     = skrs_pkg::TAG_W;
    localparam int AW     = skrs_pkg::ANC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NW-1:0] r_process_noise;
    logic [NW-1:0] r_measurement_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise     <= NW'(1) << GW;
            r_measurement_noise <= NW'(1) << GW;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                skrs_pkg::REG_PROCESS_NOISE:     r_process_noise     <= pwdata[NW-1:0];
                skrs_pkg::REG_MEASUREMENT_NOISE: r_measurement_noise <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            skrs_pkg::REG_PROCESS_NOISE:     prdata = 32'(r_process_noise);
            skrs_pkg::REG_MEASUREMENT_NOISE: prdata = 32'(r_measurement_noise);
            default:                         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [TW-1:0] w_tag;
    logic [AW-1:0] w_anc;
    logic [RW-1:0] w_range;
    logic [15:0]   w_idx_full;
    logic [ADDR_W-1:0] w_idx;
    logic          w_in_range;
    logic          w_accept;

    assign w_tag   = s_axis_tdata[TW-1:0];
    assign w_anc   = s_axis_tdata[TW+AW-1:TW];
    assign w_range = s_axis_tdata[TW+AW+RW-1:TW+AW];

    assign w_idx_full = 16'(w_tag) * 16'(NUM_ANCHORS) + 16'(w_anc);
    assign w_idx      = w_idx_full[ADDR_W-1:0];
    assign w_in_range = (9'(w_tag) < 9'(NUM_TAGS)) && (6'(w_anc) < 6'(NUM_ANCHORS));
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    skrs_pkg::t_state r_state;
    skrs_pkg::t_state n_state;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              w_div_done;
    logic              w_div_start;
    logic              w_ram_we;
    logic              w_out_load;
    logic              w_out_free;

    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            skrs_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = skrs_pkg::ST_IDLE;
                end
            end
            skrs_pkg::ST_IDLE: begin
                if (w_accept && s_axis_tuser && w_in_range) begin
                    n_state = skrs_pkg::ST_LOAD;
                end
            end
            skrs_pkg::ST_LOAD:      n_state = skrs_pkg::ST_DEN;
            skrs_pkg::ST_DEN:       n_state = skrs_pkg::ST_DIV;
            skrs_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = skrs_pkg::ST_MUL_DELTA;
                end
            end
            skrs_pkg::ST_MUL_DELTA: n_state = skrs_pkg::ST_MUL_VAR;
            skrs_pkg::ST_MUL_VAR:   n_state = skrs_pkg::ST_WRITE;
            skrs_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = skrs_pkg::ST_IDLE;
                end
            end
            default:                n_state = skrs_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_ram_we      = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            skrs_pkg::ST_CLEAR: w_ram_we      = 1'b1;
            skrs_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            skrs_pkg::ST_DEN:   w_div_start   = 1'b1;
            skrs_pkg::ST_WRITE: begin
                w_ram_we   = w_out_free;
                w_out_load = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= skrs_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == skrs_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Filter state memories
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [W-1:0]      w_est_rdata;
    logic [W-1:0]      w_var_rdata;
    logic [W-1:0]      w_est_wdata;
    logic [W-1:0]      w_var_wdata;
    logic [W-1:0]      r_xn;
    logic [W-1:0]      r_pn;

    // While idle the RAMs read at the incoming request's entry, so the
    // filter state is ready the cycle after acceptance.
    always_comb begin
        case (r_state)
            skrs_pkg::ST_CLEAR: w_ram_addr = r_clr_addr;
            skrs_pkg::ST_IDLE:  w_ram_addr = w_idx;
            default:            w_ram_addr = r_idx;
        endcase
    end

    assign w_est_wdata = (r_state == skrs_pkg::ST_CLEAR) ? '0 : r_xn;
    assign w_var_wdata = (r_state == skrs_pkg::ST_CLEAR) ? '0 : r_pn;

    skrs_ram #(.WIDTH(W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_est_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_est_wdata),
        .o_rdata (w_est_rdata)
    );

    skrs_ram #(.WIDTH(W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_var_wdata),
        .o_rdata (w_var_rdata)
    );

    // ------------------------------------------------------------------
    // Update datapath
    // ------------------------------------------------------------------
    logic [TW-1:0] r_tag;
    logic [AW-1:0] r_anc;
    logic [RW-1:0] r_range;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_pm;
    logic [W-1:0]  r_diff;
    logic          r_up;
    logic [GW-1:0] r_gain;
    logic [W-1:0]  r_delta;

    logic [W:0]    w_pm_sum;
    logic [W-1:0]  w_pm;
    logic [W:0]    w_den;
    logic [W-1:0]  w_z;
    logic [GW-1:0] w_gain;
    logic [GW+W-1:0] w_delta_prod;
    logic [GW+W:0]   w_var_prod;

    // Predicted variance saturates at the top of Q16.16.
    assign w_pm_sum = {1'b0, w_var_rdata} + (W + 1)'(r_process_noise);
    assign w_pm     = w_pm_sum[W] ? '1 : w_pm_sum[W-1:0];
    assign w_den    = {1'b0, r_pm} + (W + 1)'(r_measurement_noise);
    assign w_z      = {r_range, {(W - RW){1'b0}}};

    assign w_delta_prod = (GW + W)'(r_gain) * (GW + W)'(r_diff);
    assign w_var_prod   = (GW + W + 1)'(skrs_pkg::ONE_Q16 - (GW + 1)'(r_gain))
                        * (GW + W + 1)'(r_pm);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx   <= w_idx;
            r_tag   <= w_tag;
            r_anc   <= w_anc;
            r_range <= w_range;
        end
        case (r_state)
            skrs_pkg::ST_LOAD: begin
                r_x  <= w_est_rdata;
                r_pm <= w_pm;
            end
            skrs_pkg::ST_DEN: begin
                r_up   <= (w_z >= r_x);
                r_diff <= (w_z >= r_x) ? (w_z - r_x) : (r_x - w_z);
            end
            skrs_pkg::ST_DIV: begin
                if (w_div_done) begin
                    r_gain <= w_gain;
                end
            end
            skrs_pkg::ST_MUL_DELTA: begin
                r_delta <= w_delta_prod[GW+W-1:GW];
            end
            skrs_pkg::ST_MUL_VAR: begin
                r_pn <= w_var_prod[GW+W-1:GW];
                r_xn <= r_up ? (r_x + r_delta) : (r_x - r_delta);
            end
            default: ;
        endcase
    end

    skrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_pm),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_gain  (w_gain)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        r_m_valid;
    logic [23:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= 24'({r_anc, r_tag, r_xn[W-1:W-RW]});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == skrs_pkg::ST_WRITE))
        else $error("result appeared without a write-back");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == skrs_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_estimate_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skrs_pkg::ST_WRITE) |->
            (r_up ? (r_xn >= r_x && r_xn <= w_z) : (r_xn <= r_x && r_xn >= w_z)))
        else $error("new estimate outside old estimate and measurement");

    a_variance_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skrs_pkg::ST_WRITE) |-> (r_pn <= r_pm))
        else $error("updated variance exceeds predicted variance");

endmodule

// ----- tb/smoother_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range smoother result check
// Follows the request, result and APB channels of the range smoother. It
// keeps its own copy of the filter tables and noise registers, works out the
// filtered range that each update must give, and compares results in order.
// ----------------------------------------------------------------------------
module smoother_result_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,  // tag_index[2:0], anchor_index[4:3],
                                     // range_value[20:5], zero fill
    input  logic        i_req_user,  // range_valid
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [23:0] i_res_data,  // filtered_range[15:0], out_tag[18:16],
                                     // out_anchor[20:19], zero fill
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int DEPTH     = skrs_pkg::NUM_TAGS_DEF * skrs_pkg::NUM_ANCHORS_DEF;
    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        logic [skrs_pkg::ANC_W-1:0]   out_anchor;
        logic [skrs_pkg::TAG_W-1:0]   out_tag;
        logic [skrs_pkg::RANGE_W-1:0] filtered_range;
    } t_filtered;

    logic [skrs_pkg::DATA_W-1:0]  estimate_q16 [DEPTH];
    logic [skrs_pkg::DATA_W-1:0]  variance_q16 [DEPTH];
    logic [skrs_pkg::NOISE_W-1:0] process_noise     = 24'd65536;
    logic [skrs_pkg::NOISE_W-1:0] measurement_noise = 24'd65536;
    t_filtered                    expected_ranges [$];
    int                           fails   = 0;
    int                           checked = 0;

    // One filter update in full precision; updates the tables and returns
    // the integer part of the new estimate.
    function automatic logic [15:0] kalman_update(input int idx, input logic [15:0] meas);
        logic [63:0] x, z, pm, den, gain, diff, delta, xn, pn;
        x  = {32'd0, estimate_q16[idx]};
        z  = {32'd0, meas, 16'd0};
        pm = {32'd0, variance_q16[idx]} + {40'd0, process_noise};
        if (pm > 64'hFFFF_FFFF) begin
            pm = 64'hFFFF_FFFF;
        end
        den = pm + {40'd0, measurement_noise};
        if (den == 64'd0) begin
            gain = 64'd0;
        end else begin
            gain = (pm << 16) / den;
        end
        if (gain > 64'hFFFF) begin
            gain = 64'hFFFF;
        end
        if (z >= x) begin
            diff  = z - x;
            delta = (gain * diff) >> 16;
            xn    = x + delta;
        end else begin
            diff  = x - z;
            delta = (gain * diff) >> 16;
            xn    = x - delta;
        end
        pn = ((64'd65536 - gain) * pm) >> 16;
        estimate_q16[idx] = xn[31:0];
        variance_q16[idx] = pn[31:0];
        return xn[31:16];
    endfunction

    always @(posedge i_clk) begin : watch
        t_filtered                  want;
        t_filtered                  got;
        logic [skrs_pkg::TAG_W-1:0] tag_in;
        logic [skrs_pkg::ANC_W-1:0] anc_in;
        int                         idx;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                estimate_q16[i] = '0;
                variance_q16[i] = '0;
            end
            process_noise     = 24'd65536;
            measurement_noise = 24'd65536;
            expected_ranges.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == skrs_pkg::REG_PROCESS_NOISE) begin
                    process_noise = i_pwdata[skrs_pkg::NOISE_W-1:0];
                end else if (i_paddr[2] == skrs_pkg::REG_MEASUREMENT_NOISE) begin
                    measurement_noise = i_pwdata[skrs_pkg::NOISE_W-1:0];
                end
            end
            if (i_req_valid && i_req_ready && i_req_user) begin
                tag_in = i_req_data[2:0];
                anc_in = i_req_data[4:3];
                if (tag_in < skrs_pkg::NUM_TAGS_DEF && anc_in < skrs_pkg::NUM_ANCHORS_DEF) begin
                    idx = tag_in * skrs_pkg::NUM_ANCHORS_DEF + anc_in;
                    want.filtered_range = kalman_update(idx, i_req_data[20:5]);
                    want.out_tag        = tag_in;
                    want.out_anchor     = anc_in;
                    expected_ranges.push_back(want);
                end
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[20:0];
                if (expected_ranges.size() == 0) begin
                    fails++;
                    if (fails <= SHOWN_MAX) begin
                        $display("%0t: unexpected result range %0d tag %0d anchor %0d",
                                 $time, got.filtered_range, got.out_tag, got.out_anchor);
                    end
                end else begin
                    want = expected_ranges.pop_front();
                    checked++;
                    if (got.filtered_range !== want.filtered_range ||
                        got.out_tag !== want.out_tag || got.out_anchor !== want.out_anchor ||
                        i_res_data[23:21] !== 3'b000) begin
                        fails++;
                        if (fails <= SHOWN_MAX) begin
                            $display("%0t: mismatch: expected range %0d tag %0d anchor %0d",
                                     $time, want.filtered_range, want.out_tag,
                                     want.out_anchor);
                            $display("%0t:   got range %0d tag %0d anchor %0d fill %b",
                                     $time, got.filtered_range, got.out_tag,
                                     got.out_anchor, i_res_data[23:21]);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_ranges.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/scalar_kalman_range_smoother_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range smoother testbench
// Drives range requests and noise settings into the smoother, stalls the
// result side at random, and leaves prediction and comparison to the result
// check that sits beside the block.
// ----------------------------------------------------------------------------
module scalar_kalman_range_smoother_tb;

    // Cycles that cover one update with room to spare; used before a noise
    // write and at the very end, since a skipped request gives no result
    // that could be waited for.
    localparam int SETTLE_CYCLES     = 40;
    // No channel may sit without a handshake for this long. The slowest
    // correct stretch is a long sender gap, a long receiver stall, one update
    // and a settle pause; the reset sweep is shorter still.
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int RANDOM_PHASES     = 6;
    localparam int UPDATES_PER_PHASE = 255;
    localparam int DEPTH = skrs_pkg::NUM_TAGS_DEF * skrs_pkg::NUM_ANCHORS_DEF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int checked_results;

    // Stimulus bookkeeping and the idling modes of both sides.
    int requests_sent  = 0;
    int updates_sent   = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int rx_left        = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;

    always #5 i_clk = ~i_clk;

    scalar_kalman_range_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    smoother_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_results)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Noise values: the extremes, the reset value of 1.0, small values that
    // give a gain close to one, and anything at all.
    function automatic logic [23:0] pick_noise();
        case ($urandom_range(0, 4))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2:       return 24'd65536;
            3:       return 24'($urandom_range(0, 4096));
            default: return 24'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    // The receiver alternates ready runs with stalls. In steady mode it
    // takes every result at once, so that back-to-back updates are seen.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_left       <= 0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            rx_left       <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
            rx_left       <= $urandom_range(0, 15);
        end
    end

    // The watchdog counts cycles in which no channel completes a handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                         WATCHDOG_LIMIT, pending_results);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Presents one range request and holds it until the smoother takes it.
    // The valid line is only lowered when a gap follows, so a request that is
    // followed at once by the next one keeps valid high without a glitch.
    task automatic send_request(input logic [2:0] tag, input logic [1:0] anc,
                                input logic [15:0] rng, input logic vld);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rng, anc, tag};
        s_axis_tuser  <= vld;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        if (vld) begin
            updates_sent++;
        end
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every update has come out. A skipped
    // request gives no result to wait for, hence the pause.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup, then access until pready. The upper byte of
    // pwdata carries junk, which the register must drop.
    task automatic write_noise(input logic reg_code, input logic [23:0] value);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 2'b00};
        pwdata  <= {junk, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] truth [DEPTH];
        logic [4:0]  entry;
        logic [15:0] rng;
        logic        vld;
        bit          hot;
        int          phase_updates;

        for (int i = 0; i < DEPTH; i++) begin
            truth[i] = 16'($urandom);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset noise of 1.0: both range extremes
        // on the lowest and highest filter, a measurement below the estimate,
        // and skipped requests with live-looking data.
        send_request(3'd0, 2'd0, 16'd0, 1'b1);
        send_request(3'd0, 2'd0, 16'hFFFF, 1'b1);
        send_request(3'd7, 2'd3, 16'hFFFF, 1'b1);
        send_request(3'd7, 2'd3, 16'hFFFF, 1'b1);
        send_request(3'd7, 2'd3, 16'd0, 1'b1);
        send_request(3'd3, 2'd2, 16'h5A5A, 1'b0);
        send_request(3'd4, 2'd1, 16'hA5A5, 1'b0);
        send_request(3'd2, 2'd1, 16'hA5A5, 1'b1);
        send_request(3'd5, 2'd2, 16'h5A5A, 1'b1);

        // No noise at all: a fresh filter has a zero denominator and must
        // keep its estimate, while a used filter sees a saturated gain.
        drain();
        write_noise(skrs_pkg::REG_PROCESS_NOISE, 24'd0);
        write_noise(skrs_pkg::REG_MEASUREMENT_NOISE, 24'd0);
        settings_used++;
        send_request(3'd6, 2'd0, 16'd1000, 1'b1);
        send_request(3'd6, 2'd0, 16'd1000, 1'b1);
        send_request(3'd0, 2'd0, 16'd30000, 1'b1);

        // Largest process noise and no measurement noise: the gain saturates just below one.
        drain();
        write_noise(skrs_pkg::REG_PROCESS_NOISE, 24'hFF_FFFF);
        write_noise(skrs_pkg::REG_MEASUREMENT_NOISE, 24'd0);
        settings_used++;
        send_request(3'd1, 2'd3, 16'hFFFF, 1'b1);
        send_request(3'd1, 2'd3, 16'd1, 1'b1);
        send_request(3'd7, 2'd3, 16'd12345, 1'b1);

        // Both noises at their maximum.
        drain();
        write_noise(skrs_pkg::REG_MEASUREMENT_NOISE, 24'hFF_FFFF);
        settings_used++;
        send_request(3'd1, 2'd3, 16'd40000, 1'b1);
        send_request(3'd0, 2'd0, 16'hFFFF, 1'b1);
        send_request(3'd6, 2'd0, 16'd0, 1'b1);

        // Random phases, each under a fresh pair of noise values and its own
        // idling mode. A phase dwells on a few filters with even odds, so that their
        // estimates and variances settle over long histories; measurements
        // often scatter around a fixed true range per filter.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            write_noise(skrs_pkg::REG_PROCESS_NOISE, pick_noise());
            write_noise(skrs_pkg::REG_MEASUREMENT_NOISE, pick_noise());
            settings_used++;
            tx_steady     = ($urandom_range(0, 3) == 0);
            rx_steady     = ($urandom_range(0, 3) == 0);
            hot           = $urandom_range(0, 1);
            phase_updates = 0;
            while (phase_updates < UPDATES_PER_PHASE) begin
                vld = ($urandom_range(0, 99) < 85);
                if (hot && $urandom_range(0, 3) != 0) begin
                    entry = 5'($urandom_range(0, 3));
                end else begin
                    entry = 5'($urandom_range(0, DEPTH - 1));
                end
                case ($urandom_range(0, 9))
                    0:          rng = 16'd0;
                    1:          rng = 16'hFFFF;
                    2, 3, 4, 5: rng = truth[entry] ^ 16'($urandom_range(0, 255));
                    default:    rng = 16'($urandom);
                endcase
                send_request(entry[4:2], entry[1:0], rng, vld);
                if (vld) begin
                    phase_updates++;
                end
            end
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();

        $display("Sent %0d range requests, %0d of them filter updates, under %0d noise settings.",
                 requests_sent, updates_sent, settings_used);
        $display("Checked %0d filtered ranges: %0d failures, %0d still outstanding.",
                 checked_results, fail_count, pending_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/skrs_pkg.sv
rtl/skrs_ram.sv
rtl/skrs_div.sv
rtl/scalar_kalman_range_smoother.sv
tb/smoother_result_check.sv
tb/scalar_kalman_range_smoother_tb.sv
